// File: hw/rtl/sdf_pkg.sv
package sdf_pkg;

  // Width of the magnitude that is converted; upper input bits are ignored.
  localparam int VALUE_BITS  = 32;
  // Decimal digit slots held by the converter and walked by the emitter.
  localparam int DIGIT_SLOTS = 10;
  // Ceiling on the requested minimum digit count.
  localparam int MAX_DIGITS  = 10;

  localparam int IN_BITS    = 32;
  localparam int MIN_BITS   = 4;
  localparam int CHAR_BITS  = 8;
  localparam int BCD_BITS   = 4 * DIGIT_SLOTS;
  localparam int POS_BITS   = $clog2(DIGIT_SLOTS + 1);
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_HOLD
  } cv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGITS
  } em_state_t;

  // Converted value handed from the converter to the emitter.
  typedef struct packed {
    logic [BCD_BITS-1:0] bcd;
    logic                is_negative;
    logic [POS_BITS-1:0] req;
  } sdf_job_t;

endpackage

// File: hw/rtl/sdf_if.sv
interface sdf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] magnitude_value;
  logic        is_negative;
  logic [3:0]  min_digits;

  modport source (output valid, magnitude_value, is_negative, min_digits, input ready);
  modport sink   (input valid, magnitude_value, is_negative, min_digits, output ready);
endinterface

interface sdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

// File: hw/rtl/signed_decimal_formatter.sv
// Signed decimal formatter: magnitude + sign flag + minimum digit count in,
// ASCII text out, one character per beat.
//
// in_ch carries one value per beat (valid/ready). out_ch returns '-' first
// for a negative value, then the decimal digits, most significant first,
// zero padded to the minimum count (0 acts as 1, above 10 clamps to 10).
// The final character of each value has last_char set.
//
// Flow: a shift-and-add-3 converter consumes one magnitude bit per cycle,
// walking all VALUE_BITS (32) bits of the magnitude. The emitter then skips
// leading zero slots and walks one digit slot per cycle while the receiver
// does not stall; meanwhile the converter already works on the next value,
// so the block can accept a new value while the last one is still emitted.
//
// Reset (rst, synchronous) returns both engines to idle and drops any value
// in flight; out_ch.valid falls. When the receiver stalls, the output
// register holds its character and the emitter waits; the converter then
// finishes and holds its result, and in_ch.ready stays low until it hands off.
module signed_decimal_formatter (
  input  logic      clk,
  input  logic      rst,
  sdf_in_if.sink    in_ch,
  sdf_out_if.source out_ch
);
  import sdf_pkg::*;

  sdf_job_t job;
  logic     job_valid;
  logic     job_take;

  // Binary to BCD, one bit per cycle.
  sdf_bcd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take)
  );

  // Sign and digit emission with output register.
  sdf_char_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_take  (job_take),
    .out_ch    (out_ch)
  );

endmodule

// File: hw/rtl/sdf_bcd_conv.sv
module sdf_bcd_conv (
  input  logic              clk,
  input  logic              rst,
  sdf_in_if.sink            in_ch,
  output sdf_pkg::sdf_job_t job,
  output logic              job_valid,
  input  logic              job_take
);
  import sdf_pkg::*;

  cv_state_t               state;
  cv_state_t               state_next;
  logic [VALUE_BITS-1:0]   value;
  logic [BCD_BITS-1:0]     bcd;
  logic [BCD_BITS-1:0]     bcd_next;
  logic [CNT_BITS-1:0]     cnt;
  logic                    neg;
  logic [POS_BITS-1:0]     req;
  logic [POS_BITS-1:0]     req_sat;

  always_comb begin
    state_next = state;
    unique case (state)
      CV_IDLE:  if (in_ch.valid) state_next = CV_SHIFT;
      CV_SHIFT: if (cnt == '0) state_next = CV_HOLD;
      CV_HOLD:  if (job_take) state_next = CV_IDLE;
      default:  state_next = CV_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = (state == CV_IDLE);
    job_valid       = (state == CV_HOLD);
    job.bcd         = bcd;
    job.is_negative = neg;
    job.req         = req;
  end

  // Clamp the requested digit count to 1..MAX_DIGITS.
  always_comb begin
    if (in_ch.min_digits == '0) begin
      req_sat = POS_BITS'(1);
    end else if (in_ch.min_digits > MIN_BITS'(MAX_DIGITS)) begin
      req_sat = POS_BITS'(MAX_DIGITS);
    end else begin
      req_sat = POS_BITS'(in_ch.min_digits);
    end
  end

  // Shift-and-add-3: adjust every digit of 5 or more, then shift in the next bit.
  always_comb begin
    logic [BCD_BITS-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[BCD_BITS-2:0], value[VALUE_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == CV_IDLE && in_ch.valid) begin
      value <= in_ch.magnitude_value[VALUE_BITS-1:0];
      bcd   <= '0;
      cnt   <= CNT_BITS'(VALUE_BITS - 1);
      neg   <= in_ch.is_negative;
      req   <= req_sat;
    end else if (state == CV_SHIFT) begin
      value <= {value[VALUE_BITS-2:0], 1'b0};
      bcd   <= bcd_next;
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

// File: hw/rtl/sdf_char_emit.sv
module sdf_char_emit (
  input  logic              clk,
  input  logic              rst,
  input  sdf_pkg::sdf_job_t job,
  input  logic              job_valid,
  output logic              job_take,
  sdf_out_if.source         out_ch
);
  import sdf_pkg::*;

  em_state_t              state;
  em_state_t              state_next;
  logic [BCD_BITS-1:0]    digits;
  logic [POS_BITS-1:0]    pos;
  logic [POS_BITS-1:0]    req;
  logic                   seen;
  logic                   out_valid;
  logic [CHAR_BITS-1:0]   ascii;
  logic                   last;
  logic                   slot_free;
  logic [3:0]             top_digit;
  logic                   show;
  logic                   step;
  logic                   put_sign;
  logic                   put_digit;

  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE:   if (job_valid) state_next = job.is_negative ? EM_SIGN : EM_DIGITS;
      EM_SIGN:   if (slot_free) state_next = EM_DIGITS;
      EM_DIGITS: if (step && pos == POS_BITS'(1)) state_next = EM_IDLE;
      default:   state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    slot_free = !out_valid || out_ch.ready;
    top_digit = digits[BCD_BITS-1 -: 4];
    // Leading zeros above the requested width are dropped.
    show      = seen || (top_digit != 4'd0) || (pos <= req);
    job_take  = (state == EM_IDLE);
    step      = (state == EM_DIGITS) && (!show || slot_free);
    put_sign  = (state == EM_SIGN) && slot_free;
    put_digit = (state == EM_DIGITS) && show && slot_free;
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.ascii_char = ascii;
  assign out_ch.last_char  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (put_sign || put_digit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_sign) begin
      ascii <= CHAR_MINUS;
      last  <= 1'b0;
    end else if (put_digit) begin
      ascii <= CHAR_ZERO + {4'd0, top_digit};
      last  <= (pos == POS_BITS'(1));
    end
    if (state == EM_IDLE && job_valid) begin
      digits <= job.bcd;
      pos    <= POS_BITS'(DIGIT_SLOTS);
      req    <= job.req;
      seen   <= 1'b0;
    end else if (step) begin
      digits <= {digits[BCD_BITS-5:0], 4'd0};
      pos    <= pos - 1'b1;
      seen   <= seen || show;
    end
  end

endmodule

// File: hw/rtl/sdf_checker.sv
module sdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] ascii_char,
  input logic       last_char
);
  import sdf_pkg::*;

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(last_char))
    else $error("stalled output beat changed");

  // Only minus or a decimal digit leaves the block.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ascii_char == CHAR_MINUS ||
                  (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_ZERO + 8'd9))
    else $error("illegal output character");

  // A minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && ascii_char == CHAR_MINUS |-> !last_char)
    else $error("minus sign flagged last");

  // The converter takes one value and is busy right after.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while converting");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ascii_char (out_ch.ascii_char),
  .last_char  (out_ch.last_char)
);
